// File: src/wlc_pkg.sv
// shared constants, codes and controller/datapath interface types of the picker
`timescale 1ns / 1ps

package wlc_pkg;

    // pool and field widths
    localparam int SERVER_COUNT = 8;
    localparam int SIDX_W       = 3;
    localparam int ACT_W        = 16;
    localparam int TOT_W        = 32;
    localparam int WGT_W        = 8;
    localparam int PROD_W       = ACT_W + WGT_W;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int HEALTHY_W    = 8;

    // stream packing
    localparam int IN_TDATA_W   = 8;
    localparam int PICK_LSB     = 0;
    localparam int PRIOR_LSB    = PICK_LSB + SIDX_W;
    localparam int TOTAL_LSB    = PRIOR_LSB + ACT_W;
    localparam int PACK_W       = TOTAL_LSB + TOT_W;
    localparam int OUT_TDATA_W  = ((PACK_W + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITS_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITS_HI = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEALTHY   = 2'd3;

    // request kinds
    localparam logic REQ_ROUTE   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // result outcome codes
    typedef enum logic [1:0] {
        OUT_ROUTED   = 2'd0,
        OUT_NONE     = 2'd1,
        OUT_RELEASED = 2'd2,
        OUT_REL_IDLE = 2'd3
    } outcome_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic mul;
        logic cmp;
        logic commit;
    } wlc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic in_release;
        logic idx_last;
        logic out_free;
    } wlc_status_t;

endpackage

// File: src/wlc_datapath.sv
// picker datapath: server counters, scan registers, cross-multiply compare, output register
`timescale 1ns / 1ps

module wlc_datapath
    import wlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  wlc_cmd_t               cmd,
    output wlc_status_t            status,
    input  logic [CFG_W-1:0]       weights,
    input  logic [CFG_W-1:0]       limits_lo,
    input  logic [CFG_W-1:0]       limits_hi,
    input  logic [HEALTHY_W-1:0]   healthy,
    input  logic                   in_kind,
    input  logic [SIDX_W-1:0]      in_target,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [1:0]             out_kind,
    output logic [OUT_TDATA_W-1:0] out_data
);

    // per-server state
    logic [ACT_W-1:0]  active_reg [SERVER_COUNT];
    logic [TOT_W-1:0]  total_reg  [SERVER_COUNT];

    // item and scan registers
    logic              kind_reg;
    logic [SIDX_W-1:0] target_reg;
    logic [SIDX_W-1:0] idx_reg;
    logic              found_reg;
    logic [SIDX_W-1:0] best_reg;
    logic [ACT_W-1:0]  best_a_reg;
    logic [WGT_W-1:0]  best_w_reg;
    logic [PROD_W-1:0] lhs_reg;
    logic [PROD_W-1:0] rhs_reg;
    logic              elig_reg;
    logic [ACT_W-1:0]  cand_a_reg;
    logic [WGT_W-1:0]  cand_w_reg;

    // output register
    logic              out_valid_reg;
    outcome_t          out_kind_reg;
    logic [SIDX_W-1:0] out_pick_reg;
    logic [ACT_W-1:0]  out_prior_reg;
    logic [TOT_W-1:0]  out_total_reg;

    logic [2*CFG_W-1:0] limits_all;
    logic [SIDX_W-1:0]  rd_idx;
    logic [ACT_W-1:0]   rd_a;
    logic [WGT_W-1:0]   cur_w;
    logic [ACT_W-1:0]   cur_lim;
    logic               target_oor;
    logic [TOT_W-1:0]   best_total_inc;
    logic               take_cand;

    // one read port on the active counts: scan index, or release target
    assign rd_idx     = (kind_reg == REQ_RELEASE) ? target_reg : idx_reg;
    assign rd_a       = active_reg[rd_idx];
    assign limits_all = {limits_hi, limits_lo};
    assign cur_w      = weights[{idx_reg, 3'b000} +: WGT_W];
    assign cur_lim    = limits_all[{idx_reg, 4'b0000} +: ACT_W];
    assign target_oor = ({1'b0, target_reg} >= (SIDX_W + 1)'(SERVER_COUNT));
    assign best_total_inc = total_reg[best_reg] + TOT_W'(1);
    assign take_cand  = elig_reg && (!found_reg || (lhs_reg < rhs_reg));

    // status back to the controller
    assign status.in_release = in_kind;
    assign status.idx_last   = (idx_reg == SIDX_W'(SERVER_COUNT - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    // scan control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.cmp)
        begin
            idx_reg <= idx_reg + SIDX_W'(1);
            if (take_cand)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // item capture, products of the candidate, best tracking
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= in_kind;
            target_reg <= in_target;
        end
        if (cmd.mul)
        begin
            lhs_reg    <= PROD_W'(rd_a) * PROD_W'(best_w_reg);
            rhs_reg    <= PROD_W'(best_a_reg) * PROD_W'(cur_w);
            elig_reg   <= healthy[idx_reg] && (cur_w != '0) && (rd_a < cur_lim);
            cand_a_reg <= rd_a;
            cand_w_reg <= cur_w;
        end
        if (cmd.cmp && take_cand)
        begin
            best_reg   <= idx_reg;
            best_a_reg <= cand_a_reg;
            best_w_reg <= cand_w_reg;
        end
    end

    // server counters, updated at most once per item at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SERVER_COUNT; i++)
            begin
                active_reg[i] <= '0;
                total_reg[i]  <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (kind_reg == REQ_ROUTE)
            begin
                if (found_reg)
                begin
                    active_reg[best_reg] <= best_a_reg + ACT_W'(1);
                    total_reg[best_reg]  <= best_total_inc;
                end
            end
            else if (!target_oor && (rd_a != '0))
            begin
                active_reg[target_reg] <= rd_a - ACT_W'(1);
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (kind_reg == REQ_ROUTE)
            begin
                if (found_reg)
                begin
                    out_kind_reg  <= OUT_ROUTED;
                    out_pick_reg  <= best_reg;
                    out_prior_reg <= best_a_reg;
                    out_total_reg <= best_total_inc;
                end
                else
                begin
                    out_kind_reg  <= OUT_NONE;
                    out_pick_reg  <= '0;
                    out_prior_reg <= '0;
                    out_total_reg <= '0;
                end
            end
            else
            begin
                out_pick_reg  <= target_reg;
                out_total_reg <= '0;
                if (target_oor)
                begin
                    out_kind_reg  <= OUT_REL_IDLE;
                    out_prior_reg <= '0;
                end
                else
                begin
                    out_kind_reg  <= (rd_a == '0) ? OUT_REL_IDLE : OUT_RELEASED;
                    out_prior_reg <= rd_a;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = {(OUT_TDATA_W - PACK_W)'(0), out_total_reg, out_prior_reg, out_pick_reg};

endmodule

// File: src/wlc_ctrl.sv
// picker controller: item accept, per-server multiply/compare sequencing, commit
`timescale 1ns / 1ps

module wlc_ctrl
    import wlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output wlc_cmd_t    cmd,
    input  wlc_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_CMP  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // commands
    assign cmd.capture = accept;
    assign cmd.mul     = (state_reg == S_MUL);
    assign cmd.cmp     = (state_reg == S_CMP);
    assign cmd.commit  = (state_reg == S_FIN) && status.out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.in_release ? S_FIN : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = status.idx_last ? S_FIN : S_MUL;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/weighted_least_connection_picker.sv
// top level of the weighted least-connection picker: config registers, controller, datapath
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser = req_type, s_tdata = target_server
//  m_       out  m_tvalid/m_tready  m_tuser = outcome,
//                                   m_tdata = picked_server, prior_active, served_total
//  cfg_     in   cfg_we             cfg_index selects register, cfg_data is the value
//
//  route item: accept, then for each server a multiply step and a compare step
//  (multiply, then compare against the running best), then commit
//  release item: accept, then commit on one read of the active count
//  the result sits in an output register; the next item is taken while it waits,
//  commit stalls only while the output register is still full and not taken
//  reset clears all active counts and request totals and loads default config
`timescale 1ns / 1ps

module weighted_least_connection_picker
    import wlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] target_server
    input  logic                   s_tuser,   // [0] req_type
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [2:0] picked_server, [18:3] prior_active,
                                              // [50:19] served_total
    output logic [1:0]             m_tuser,   // [1:0] outcome
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [CFG_W-1:0]     weights_reg;
    logic [CFG_W-1:0]     limits_lo_reg;
    logic [CFG_W-1:0]     limits_hi_reg;
    logic [HEALTHY_W-1:0] healthy_reg;
    wlc_cmd_t             cmd;
    wlc_status_t          status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg   <= 64'h0101_0101_0101_0101;
            limits_lo_reg <= '1;
            limits_hi_reg <= '1;
            healthy_reg   <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WEIGHTS:   weights_reg   <= cfg_data;
                CFG_LIMITS_LO: limits_lo_reg <= cfg_data;
                CFG_LIMITS_HI: limits_hi_reg <= cfg_data;
                CFG_HEALTHY:   healthy_reg   <= cfg_data[HEALTHY_W-1:0];
            endcase
        end
    end

    // controller
    wlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath
    wlc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .weights   (weights_reg),
        .limits_lo (limits_lo_reg),
        .limits_hi (limits_hi_reg),
        .healthy   (healthy_reg),
        .in_kind   (s_tuser),
        .in_target (s_tdata[SIDX_W-1:0]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_data  (m_tdata)
    );

    // one item in flight: no accept in the cycle after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is still in work");

    // no eligible server gives an all-zero payload
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == OUT_NONE) |-> (m_tdata == '0))
        else $error("no-server result carries nonzero fields");

    // releases never report a request total
    a_release_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == OUT_RELEASED) || (m_tuser == OUT_REL_IDLE))
        |-> (m_tdata[TOTAL_LSB +: TOT_W] == '0))
        else $error("release result carries a request total");

    // a release on an idle server saw a zero active count
    a_idle_prior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == OUT_REL_IDLE) |-> (m_tdata[PRIOR_LSB +: ACT_W] == '0))
        else $error("idle release with nonzero prior active count");

endmodule

// File: test/tb_weighted_least_connection_picker.sv
// self-checking testbench for the weighted least-connection picker
`timescale 1ns / 1ps

module tb_weighted_least_connection_picker;
    import wlc_pkg::*;

    localparam int CYCLE_LIMIT = 600_000;
    localparam int DRAIN_LIMIT = 4_000;

    // one expected result item
    typedef struct {
        outcome_t           outcome;
        logic [SIDX_W-1:0]  server;
        logic [ACT_W-1:0]   prior;
        logic [TOT_W-1:0]   total;
    } pick_result_t;

    // receiver stall patterns
    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_CHOKED} rx_mode_t;

    // tracks pool state and config, predicts each result item and checks it
    class pick_scoreboard;
        logic [CFG_W-1:0]     weights;
        logic [CFG_W-1:0]     limits_lo;
        logic [CFG_W-1:0]     limits_hi;
        logic [HEALTHY_W-1:0] healthy;
        logic [ACT_W-1:0]     active [SERVER_COUNT];
        logic [TOT_W-1:0]     served [SERVER_COUNT];
        pick_result_t         pending_picks[$];
        int                   errors;
        int                   requests;
        int                   cfg_writes;
        int                   outcome_hits [4];

        function new();
            weights   = 64'h0101_0101_0101_0101;
            limits_lo = '1;
            limits_hi = '1;
            healthy   = '1;
            for (int i = 0; i < SERVER_COUNT; i++)
            begin
                active[i] = '0;
                served[i] = '0;
            end
            errors     = 0;
            requests   = 0;
            cfg_writes = 0;
            for (int i = 0; i < 4; i++)
                outcome_hits[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            cfg_writes++;
            case (idx)
                CFG_WEIGHTS:   weights   = val;
                CFG_LIMITS_LO: limits_lo = val;
                CFG_LIMITS_HI: limits_hi = val;
                CFG_HEALTHY:   healthy   = val[HEALTHY_W-1:0];
                default: ;
            endcase
        endfunction

        // update the pool for one accepted item and queue its result
        function void note_request(logic req, logic [SIDX_W-1:0] tgt);
            pick_result_t  r;
            bit            found;
            int            best;
            int unsigned   w;
            int unsigned   lim;
            int unsigned   lhs;
            int unsigned   rhs;

            requests++;
            r.outcome = OUT_NONE;
            r.server  = '0;
            r.prior   = '0;
            r.total   = '0;
            found     = 0;
            best      = 0;
            if (req == REQ_ROUTE)
            begin
                // scan eligible servers, exact ratio compare, lowest index on ties
                for (int i = 0; i < SERVER_COUNT; i++)
                begin
                    w   = 32'(weights[8*i +: 8]);
                    lim = (i < 4) ? 32'(limits_lo[16*i +: 16]) : 32'(limits_hi[16*(i-4) +: 16]);
                    if (!healthy[i] || w == 0 || 32'(active[i]) >= lim)
                        continue;
                    if (!found)
                    begin
                        found = 1;
                        best  = i;
                    end
                    else
                    begin
                        lhs = 32'(active[i]) * 32'(weights[8*best +: 8]);
                        rhs = 32'(active[best]) * w;
                        if (lhs < rhs)
                            best = i;
                    end
                end
                if (found)
                begin
                    r.outcome    = OUT_ROUTED;
                    r.server     = best[SIDX_W-1:0];
                    r.prior      = active[best];
                    active[best] = active[best] + ACT_W'(1);
                    served[best] = served[best] + TOT_W'(1);
                    r.total      = served[best];
                end
            end
            else
            begin
                r.server = tgt;
                if (int'(tgt) >= SERVER_COUNT)
                    r.outcome = OUT_REL_IDLE;
                else
                begin
                    r.prior = active[tgt];
                    if (active[tgt] == '0)
                        r.outcome = OUT_REL_IDLE;
                    else
                    begin
                        active[tgt] = active[tgt] - ACT_W'(1);
                        r.outcome   = OUT_RELEASED;
                    end
                end
            end
            pending_picks.push_back(r);
        endfunction

        // compare one accepted result item with the oldest expectation
        function void check_result(outcome_t outcome, logic [SIDX_W-1:0] server,
                                   logic [ACT_W-1:0] prior, logic [TOT_W-1:0] total);
            pick_result_t e;

            if (pending_picks.size() == 0)
            begin
                $error("result item with nothing expected: outcome %0d server %0d",
                       outcome, server);
                errors++;
                return;
            end
            e = pending_picks.pop_front();
            outcome_hits[e.outcome]++;
            if (outcome !== e.outcome)
            begin
                $error("outcome: expected %0d, got %0d", e.outcome, outcome);
                errors++;
            end
            if (server !== e.server)
            begin
                $error("picked_server: expected %0d, got %0d", e.server, server);
                errors++;
            end
            if (prior !== e.prior)
            begin
                $error("prior_active: expected %0d, got %0d", e.prior, prior);
                errors++;
            end
            if (total !== e.total)
            begin
                $error("served_total: expected %0d, got %0d", e.total, total);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    pick_scoreboard sb;
    int             cycle_count;
    rx_mode_t       rx_mode;
    int             rx_left;
    int             rx_tick;

    weighted_least_connection_picker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[weighted_least_connection_picker] ERROR");
            $finish;
        end
    end

    // receiver backpressure, switching to a new random pattern after each random-length run
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_tready <= (rx_tick % 5 == 0);
            default:   m_tready <= (rx_tick % 16 >= 12);
        endcase
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(outcome_t'(m_tuser), m_tdata[PICK_LSB +: SIDX_W],
                            m_tdata[PRIOR_LSB +: ACT_W], m_tdata[TOTAL_LSB +: TOT_W]);
    end

    // offer one item and hold it until taken
    task automatic drive_item(logic req, logic [SIDX_W-1:0] tgt);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= IN_TDATA_W'(tgt);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(req, tgt);
    endtask

    task automatic idle_gap(int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_picks.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending_picks.size() != 0)
        begin
            $error("%0d expected result items never arrived", sb.pending_picks.size());
            sb.errors += sb.pending_picks.size();
            sb.pending_picks.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(logic [CFG_W-1:0] w, logic [CFG_W-1:0] llo,
                                 logic [CFG_W-1:0] lhi, logic [HEALTHY_W-1:0] h);
        write_cfg(CFG_WEIGHTS, w);
        write_cfg(CFG_LIMITS_LO, llo);
        write_cfg(CFG_LIMITS_HI, lhi);
        write_cfg(CFG_HEALTHY, CFG_W'(h));
    endtask

    initial
    begin
        logic [CFG_W-1:0]     w;
        logic [CFG_W-1:0]     llo;
        logic [CFG_W-1:0]     lhi;
        logic [HEALTHY_W-1:0] h;
        logic [ACT_W-1:0]     lim;
        logic                 req;
        int                   route_pct;
        int                   burst_left;
        int                   phase_len;
        bit                   no_gaps;

        sb          = new();
        cycle_count = 0;
        rx_mode     = RX_OPEN;
        rx_left     = 0;
        rx_tick     = 0;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default pool: tie breaking, release of a busy and of an idle server
        drive_item(REQ_ROUTE, 3'd5);
        drive_item(REQ_ROUTE, 3'd0);
        drive_item(REQ_RELEASE, 3'd0);
        drive_item(REQ_RELEASE, 3'd0);
        drive_item(REQ_RELEASE, 3'd7);
        drive_item(REQ_ROUTE, 3'd7);
        drain();

        // zero and full weights, tiny and zero limits, some servers down
        apply_setting(64'hFF00_0302_0100_0401, 64'h0000_0001_0002_0003,
                      64'hFFFF_0004_0000_0002, 8'b1101_1011);
        repeat (10) drive_item(REQ_ROUTE, 3'd0);
        drive_item(REQ_RELEASE, 3'd0);
        drive_item(REQ_RELEASE, 3'd6);
        drive_item(REQ_RELEASE, 3'd5);
        drive_item(REQ_ROUTE, 3'd2);
        drain();

        // whole pool unhealthy, then every weight zero
        write_cfg(CFG_HEALTHY, '0);
        drive_item(REQ_ROUTE, 3'd0);
        drive_item(REQ_RELEASE, 3'd1);
        drain();
        apply_setting('0, '1, '1, 8'hFF);
        drive_item(REQ_ROUTE, 3'd0);
        drain();

        // random phases, each with its own setting and traffic mix
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
                apply_setting('1, '1, '1, 8'hFF);
            else if (ph == 1)
                apply_setting(64'h0101_0101_0101_0101, '0, '0, 8'hFF);
            else
            begin
                for (int s = 0; s < SERVER_COUNT; s++)
                begin
                    case ($urandom_range(0, 7))
                        0:       w[8*s +: 8] = 8'd0;
                        1:       w[8*s +: 8] = 8'hFF;
                        default: w[8*s +: 8] = 8'($urandom_range(1, 255));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       lim = '0;
                        1:       lim = '1;
                        2:       lim = ACT_W'($urandom());
                        default: lim = ACT_W'($urandom_range(1, 12));
                    endcase
                    if (s < 4)
                        llo[16*s +: 16] = lim;
                    else
                        lhi[16*(s-4) +: 16] = lim;
                end
                case ($urandom_range(0, 7))
                    0:       h = '0;
                    1:       h = '1;
                    default: h = HEALTHY_W'($urandom());
                endcase
                apply_setting(w, llo, lhi, h);
            end

            route_pct  = $urandom_range(35, 70);
            no_gaps    = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 30);
            phase_len  = (ph == 1) ? 60 : 260;
            for (int n = 0; n < phase_len; n++)
            begin
                if (burst_left == 0)
                begin
                    if (!no_gaps)
                        idle_gap($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 30);
                end
                burst_left--;
                req = ($urandom_range(1, 100) <= route_pct) ? REQ_ROUTE : REQ_RELEASE;
                drive_item(req, SIDX_W'($urandom_range(0, 7)));
            end
            drain();
        end

        // let any stray result show up
        repeat (40) @(posedge clk);

        $display("ran %0d request items over %0d register writes", sb.requests,
                 sb.cfg_writes);
        $display("outcomes: %0d routed, %0d no server, %0d released, %0d idle release",
                 sb.outcome_hits[OUT_ROUTED], sb.outcome_hits[OUT_NONE],
                 sb.outcome_hits[OUT_RELEASED], sb.outcome_hits[OUT_REL_IDLE]);
        if (sb.errors == 0)
            $display("[weighted_least_connection_picker] OK");
        else
            $display("[weighted_least_connection_picker] ERROR");
        $finish;
    end

endmodule

// File: weighted_least_connection_picker.f
src/wlc_pkg.sv
src/wlc_datapath.sv
src/wlc_ctrl.sv
src/weighted_least_connection_picker.sv
test/tb_weighted_least_connection_picker.sv
